// ===== rtl/relaxed_timing_criticality_macros.svh =====
// ----------------------------------------------------------------------------
// Relaxed timing criticality assertion macros
// Shared concurrent assertion forms for the criticality scorer modules.
// ----------------------------------------------------------------------------
`ifndef RELAXED_TIMING_CRITICALITY_MACROS_SVH
`define RELAXED_TIMING_CRITICALITY_MACROS_SVH

// same-cycle implication
`define RTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Relaxed timing criticality package
// Operation and error codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package rtc_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SCORE = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_PAIR_MISS = 2'd1,
      ERR_BAD_REQ   = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_CLASSIFY,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic shift;
      logic classify;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic load_op;
      logic is_last;
      logic need_div;
      logic rsp_busy;
   } status_type;

endpackage

// ===== rtl/relaxed_timing_criticality.sv =====
// ----------------------------------------------------------------------------
// Relaxed timing criticality scorer
// Scores slack tags against a per domain pair table and reports the worst
// criticality of each node with a sticky error code.
// ----------------------------------------------------------------------------
// A table load (op 0) is written on acceptance; the controller stays idle. A
// scored tag (op 1) steps through shift, classify, divide for a true division
// (the restoring divider yields one quotient bit per cycle) and finish; a tag
// that resolves to zero, one, or an error skips the divide. Requests stall
// until the tag commits. The last tag's result sits in an output register, so
// the next transaction is accepted while it waits; only a following last tag
// holds until that result is taken. Criticality is unsigned Q1.CRIT_FRAC_BITS.
module relaxed_timing_criticality #(
   parameter int NUM_DOMAINS    = 4,
   parameter int TIME_WIDTH     = 32,
   parameter int CRIT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [1:0]                req_launch_domain,
   input  logic [1:0]                req_capture_domain,
   input  logic signed [31:0]        req_slack_ps,
   input  logic signed [31:0]        req_max_required_ps,
   input  logic signed [31:0]        req_worst_pair_slack_ps,
   input  logic                      req_last_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CRIT_FRAC_BITS:0]   rsp_max_criticality,
   output logic [1:0]                rsp_error_code
);

   rtc_pkg::cmd_type    cmd;
   rtc_pkg::status_type status;

   rtc_ctrl #(
      .CRIT_FRAC_BITS (CRIT_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rtc_datapath #(
      .NUM_DOMAINS    (NUM_DOMAINS),
      .TIME_WIDTH     (TIME_WIDTH),
      .CRIT_FRAC_BITS (CRIT_FRAC_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_op                  (req_op),
      .req_launch_domain       (req_launch_domain),
      .req_capture_domain      (req_capture_domain),
      .req_slack_ps            (req_slack_ps),
      .req_max_required_ps     (req_max_required_ps),
      .req_worst_pair_slack_ps (req_worst_pair_slack_ps),
      .req_last_tag            (req_last_tag),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_max_criticality     (rsp_max_criticality),
      .rsp_error_code          (rsp_error_code),
      .cmd                     (cmd),
      .status                  (status)
   );

endmodule

// ===== rtl/rtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Relaxed timing criticality controller
// Sequences capture, shift, classify, serial divide and commit of one transaction.
// ----------------------------------------------------------------------------
`include "relaxed_timing_criticality_macros.svh"

module rtc_ctrl #(
   parameter int CRIT_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rtc_pkg::status_type  status,
   output rtc_pkg::cmd_type     cmd
);

   localparam int CW = $clog2(CRIT_FRAC_BITS);
   localparam logic [CW-1:0] DIV_LAST = CW'(CRIT_FRAC_BITS - 1);

   rtc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rtc_pkg::ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         rtc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!status.load_op) begin
                  state_in = rtc_pkg::ST_SHIFT;
               end
            end
         end
         rtc_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = rtc_pkg::ST_CLASSIFY;
         end
         rtc_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            div_cnt_in   = '0;
            state_in     = status.need_div ? rtc_pkg::ST_DIV : rtc_pkg::ST_FINISH;
         end
         rtc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = rtc_pkg::ST_FINISH;
            end else begin
               div_cnt_in = div_cnt_ff + CW'(1);
            end
         end
         rtc_pkg::ST_FINISH: begin
            // a last tag holds while the previous result is still waiting
            if (!(status.is_last && status.rsp_busy)) begin
               cmd.commit = 1'b1;
               state_in   = rtc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtc_pkg::ST_IDLE;
         end
      endcase
   end

   `RTC_ASSERT_NEXT(a_load_stays_idle, clock, reset, (state_ff == rtc_pkg::ST_IDLE) && req_valid && status.load_op, state_ff == rtc_pkg::ST_IDLE)
   `RTC_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == rtc_pkg::ST_DIV) && (div_cnt_ff == DIV_LAST), state_ff == rtc_pkg::ST_FINISH)
   `RTC_ASSERT_NEXT(a_hold_result, clock, reset, (state_ff == rtc_pkg::ST_FINISH) && status.is_last && status.rsp_busy, state_ff == rtc_pkg::ST_FINISH)

endmodule

// ===== rtl/rtc_datapath.sv =====
// ----------------------------------------------------------------------------
// Relaxed timing criticality datapath
// Domain pair table, slack shift, case split, restoring divider, running max
// and the result register.
// ----------------------------------------------------------------------------
`include "relaxed_timing_criticality_macros.svh"

module rtc_datapath #(
   parameter int NUM_DOMAINS    = 4,
   parameter int TIME_WIDTH     = 32,
   parameter int CRIT_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_op,
   input  logic [1:0]                req_launch_domain,
   input  logic [1:0]                req_capture_domain,
   input  logic signed [31:0]        req_slack_ps,
   input  logic signed [31:0]        req_max_required_ps,
   input  logic signed [31:0]        req_worst_pair_slack_ps,
   input  logic                      req_last_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CRIT_FRAC_BITS:0]   rsp_max_criticality,
   output logic [1:0]                rsp_error_code,
   input  rtc_pkg::cmd_type          cmd,
   output rtc_pkg::status_type       status
);

   localparam int TW    = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
   localparam int SW    = TW + 1;
   localparam int F     = CRIT_FRAC_BITS;
   localparam int PAIRS = NUM_DOMAINS * NUM_DOMAINS;
   localparam int IDX_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam logic [F:0] CRIT_ONE = {1'b1, {F{1'b0}}};

   logic [TW-1:0] req_mem   [PAIRS];
   logic [TW-1:0] worst_mem [PAIRS];
   logic [PAIRS-1:0] pair_valid_ff;

   logic [31:0]      idx_full;
   logic [IDX_W-1:0] idx;
   logic             in_range;
   logic             hit_now;

   logic [TW-1:0]   slack_ff, rd_req_ff, rd_worst_ff;
   logic            last_ff, hit_ff;
   logic signed [SW-1:0] slack_s_ff, req_s_ff, slack_s_in, req_s_in;
   logic signed [SW-1:0] slack_ext, req_ext, worst_ext, adj;
   logic signed [SW-1:0] num;

   logic [F:0]       crit_ff, crit_in;
   logic             ok_ff, ok_in;
   rtc_pkg::err_type err_ff, err_in;
   logic [TW-1:0]    rem_ff, rem_in, den_ff;
   logic [TW:0]      rem_two;
   logic             rem_ge;

   logic [F:0]       run_max_ff, new_max;
   rtc_pkg::err_type sticky_ff, new_err;
   logic             rsp_valid_ff;
   logic [F:0]       rsp_crit_ff;
   rtc_pkg::err_type rsp_err_ff;

   assign idx_full = 32'(req_launch_domain) * 32'(NUM_DOMAINS) + 32'(req_capture_domain);
   assign idx      = idx_full[IDX_W-1:0];
   assign in_range = (32'(req_launch_domain) < 32'(NUM_DOMAINS))
                  && (32'(req_capture_domain) < 32'(NUM_DOMAINS));
   assign hit_now  = in_range && pair_valid_ff[idx];

   // table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (req_op == rtc_pkg::OP_LOAD) begin
            if (in_range) begin
               req_mem[idx]   <= req_max_required_ps[TW-1:0];
               worst_mem[idx] <= req_worst_pair_slack_ps[TW-1:0];
            end
         end else begin
            rd_req_ff   <= req_mem[idx];
            rd_worst_ff <= worst_mem[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= '0;
      end else if (cmd.capture && (req_op == rtc_pkg::OP_LOAD) && in_range) begin
         pair_valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slack_ff <= req_slack_ps[TW-1:0];
         last_ff  <= req_last_tag;
         hit_ff   <= hit_now;
      end
   end

   // shift by the pair's negative worst slack
   always_comb begin
      slack_ext  = $signed({slack_ff[TW-1], slack_ff});
      req_ext    = $signed({rd_req_ff[TW-1], rd_req_ff});
      worst_ext  = $signed({rd_worst_ff[TW-1], rd_worst_ff});
      adj        = (worst_ext < 0) ? worst_ext : '0;
      slack_s_in = slack_ext - adj;
      req_s_in   = req_ext - adj;
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         slack_s_ff <= slack_s_in;
         req_s_ff   <= req_s_in;
      end
   end

   // split into fixed outcomes or a division
   always_comb begin
      num    = req_s_ff - slack_s_ff;
      ok_in  = 1'b0;
      err_in = rtc_pkg::ERR_NONE;
      crit_in = '0;
      if (!hit_ff) begin
         err_in = rtc_pkg::ERR_PAIR_MISS;
      end else if (req_s_ff > 0) begin
         ok_in = 1'b1;
         if (slack_s_ff <= 0) begin
            crit_in = CRIT_ONE;
         end
      end else if ((req_s_ff == 0) && (slack_s_ff == 0)) begin
         ok_in   = 1'b1;
         crit_in = CRIT_ONE;
      end else begin
         err_in = rtc_pkg::ERR_BAD_REQ;
      end
   end

   assign status.need_div = hit_ff && (req_s_ff > 0) && (slack_s_ff > 0)
                         && (slack_s_ff < req_s_ff);

   // restoring divider, one quotient bit per step
   assign rem_two = {rem_ff, 1'b0};
   assign rem_ge  = rem_two >= {1'b0, den_ff};
   assign rem_in  = rem_ge ? TW'(rem_two - {1'b0, den_ff}) : rem_two[TW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         ok_ff   <= ok_in;
         err_ff  <= err_in;
         crit_ff <= crit_in;
         rem_ff  <= num[TW-1:0];
         den_ff  <= req_s_ff[TW-1:0];
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         crit_ff <= {crit_ff[F-1:0], rem_ge};
      end
   end

   // running max and sticky error
   assign new_max = (ok_ff && (crit_ff > run_max_ff)) ? crit_ff : run_max_ff;
   assign new_err = (sticky_ff == rtc_pkg::ERR_NONE) ? err_ff : sticky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_max_ff <= '0;
         sticky_ff  <= rtc_pkg::ERR_NONE;
      end else if (cmd.commit) begin
         if (last_ff) begin
            run_max_ff <= '0;
            sticky_ff  <= rtc_pkg::ERR_NONE;
         end else begin
            run_max_ff <= new_max;
            sticky_ff  <= new_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && last_ff) begin
         rsp_crit_ff <= new_max;
         rsp_err_ff  <= new_err;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_max_criticality = rsp_crit_ff;
   assign rsp_error_code      = rsp_err_ff;

   assign status.load_op  = (req_op == rtc_pkg::OP_LOAD);
   assign status.is_last  = last_ff;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   `RTC_ASSERT_NEXT(a_node_clear, clock, reset, cmd.commit && last_ff, (run_max_ff == '0) && (sticky_ff == rtc_pkg::ERR_NONE) && rsp_valid_ff)
   `RTC_ASSERT_IMPLY(a_crit_bound, clock, reset, 1'b1, run_max_ff <= CRIT_ONE)

endmodule

// ===== tb/sv/tb_relaxed_timing_criticality.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relaxed timing criticality scorer testbench
// Loads the domain pair table and scores slack tags, first with directed
// corner cases, then with random nodes under four idle and stall mixes.
// Each node result is checked against an in-bench model of the table, the
// slack shift, the fixed point division, the running maximum and the sticky
// error code.
// ----------------------------------------------------------------------------
module tb_relaxed_timing_criticality;

   localparam int CLK_PERIOD     = 10;
   localparam int CRIT_FRAC_BITS = 16;
   localparam int CRIT_W         = CRIT_FRAC_BITS + 1;
   localparam longint CRIT_ONE   = 64'sd1 << CRIT_FRAC_BITS;
   localparam int LIMIT_CYCLES   = 500000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int RANDOM_ITEMS   = 500;

   typedef struct {
      logic               op;
      logic [1:0]         launch;
      logic [1:0]         capture;
      logic signed [31:0] slack;
      logic signed [31:0] req;
      logic signed [31:0] worst;
      logic               last;
   } timing_txn_type;

   typedef struct packed {
      logic [CRIT_W-1:0] crit;
      rtc_pkg::err_type  err;
   } node_score_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_op = rtc_pkg::OP_LOAD;
   logic [1:0]               req_launch_domain = '0;
   logic [1:0]               req_capture_domain = '0;
   logic signed [31:0]       req_slack_ps = '0;
   logic signed [31:0]       req_max_required_ps = '0;
   logic signed [31:0]       req_worst_pair_slack_ps = '0;
   logic                     req_last_tag = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CRIT_W-1:0]        rsp_max_criticality;
   logic [1:0]               rsp_error_code;

   logic                     pair_loaded [16];
   logic signed [31:0]       pair_req_ps [16];
   logic signed [31:0]       pair_worst_ps [16];
   logic [CRIT_W-1:0]        node_max_crit;
   rtc_pkg::err_type         node_error;
   node_score_type           expected_node_scores [$];
   node_score_type           oldest_score;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int nodes_checked      = 0;
   int tags_scored        = 0;
   int loads_sent         = 0;
   int cycle_count        = 0;

   relaxed_timing_criticality #(
      .NUM_DOMAINS    (4),
      .TIME_WIDTH     (32),
      .CRIT_FRAC_BITS (CRIT_FRAC_BITS)
   ) u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_op                  (req_op),
      .req_launch_domain       (req_launch_domain),
      .req_capture_domain      (req_capture_domain),
      .req_slack_ps            (req_slack_ps),
      .req_max_required_ps     (req_max_required_ps),
      .req_worst_pair_slack_ps (req_worst_pair_slack_ps),
      .req_last_tag            (req_last_tag),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_max_criticality     (rsp_max_criticality),
      .rsp_error_code          (rsp_error_code)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d node results outstanding",
                  cycle_count, expected_node_scores.size());
         $display("** relaxed_timing_criticality: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // check each node result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         nodes_checked++;
         if (expected_node_scores.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: crit %0d error %0d",
                        rsp_max_criticality, rsp_error_code);
         end else begin
            oldest_score = expected_node_scores.pop_front();
            if (rsp_max_criticality !== oldest_score.crit ||
                rsp_error_code !== oldest_score.err) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected crit %0d error %0d, got crit %0d error %0d",
                           oldest_score.crit, oldest_score.err,
                           rsp_max_criticality, rsp_error_code);
            end
         end
      end
   end

   function automatic void note_node_error(input rtc_pkg::err_type code);
      if (node_error == rtc_pkg::ERR_NONE)
         node_error = code;
   endfunction

   function automatic void predict_node_score(input timing_txn_type t);
      int unsigned       idx;
      longint            slack_v;
      longint            req_v;
      longint            worst_v;
      logic [CRIT_W-1:0] crit;
      bit                ok;
      node_score_type    score;
      idx = 32'({t.launch, t.capture});
      if (t.op == rtc_pkg::OP_LOAD) begin
         loads_sent++;
         pair_loaded[idx]   = 1'b1;
         pair_req_ps[idx]   = t.req;
         pair_worst_ps[idx] = t.worst;
      end else begin
         tags_scored++;
         if (!pair_loaded[idx]) begin
            note_node_error(rtc_pkg::ERR_PAIR_MISS);
         end else begin
            slack_v = t.slack;
            req_v   = pair_req_ps[idx];
            worst_v = pair_worst_ps[idx];
            ok      = 1'b1;
            crit    = '0;
            if (worst_v < 0) begin
               slack_v -= worst_v;
               req_v   -= worst_v;
            end
            if (req_v > 0) begin
               if (slack_v <= 0)
                  crit = CRIT_W'(CRIT_ONE);
               else if (slack_v < req_v)
                  crit = CRIT_W'(((req_v - slack_v) <<< CRIT_FRAC_BITS) / req_v);
            end else if (req_v == 0 && slack_v == 0) begin
               crit = CRIT_W'(CRIT_ONE);
            end else begin
               ok = 1'b0;
               note_node_error(rtc_pkg::ERR_BAD_REQ);
            end
            if (ok && crit > node_max_crit)
               node_max_crit = crit;
         end
         if (t.last) begin
            score.crit = node_max_crit;
            score.err  = node_error;
            expected_node_scores.insert(expected_node_scores.size(), score);
            node_max_crit = '0;
            node_error    = rtc_pkg::ERR_NONE;
         end
      end
   endfunction

   task automatic send_txn(input timing_txn_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_op                  <= t.op;
      req_launch_domain       <= t.launch;
      req_capture_domain      <= t.capture;
      req_slack_ps            <= t.slack;
      req_max_required_ps     <= t.req;
      req_worst_pair_slack_ps <= t.worst;
      req_last_tag            <= t.last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_node_score(t);
   endtask

   task automatic load_pair(input logic [1:0] la, input logic [1:0] ca,
                            input logic signed [31:0] req, input logic signed [31:0] worst);
      timing_txn_type t;
      t.op      = rtc_pkg::OP_LOAD;
      t.launch  = la;
      t.capture = ca;
      t.req     = req;
      t.worst   = worst;
      t.slack   = $urandom;
      t.last    = 1'($urandom_range(1));
      send_txn(t);
   endtask

   task automatic score_tag(input logic [1:0] la, input logic [1:0] ca,
                            input logic signed [31:0] slack, input logic last);
      timing_txn_type t;
      t.op      = rtc_pkg::OP_SCORE;
      t.launch  = la;
      t.capture = ca;
      t.slack   = slack;
      t.last    = last;
      t.req     = $urandom;
      t.worst   = $urandom;
      send_txn(t);
   endtask

   function automatic logic signed [31:0] pick_time();
      case ($urandom_range(9))
         0:       pick_time = 32'sh7fff_ffff;
         1:       pick_time = 32'sh8000_0000;
         2:       pick_time = '0;
         3:       pick_time = $signed($urandom_range(100)) - 50;
         4, 5, 6: pick_time = $urandom_range(1, 100000);
         default: pick_time = $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_required();
      if ($urandom_range(99) < 60)
         pick_required = $urandom_range(1, 1000000);
      else
         pick_required = pick_time();
   endfunction

   function automatic logic signed [31:0] pick_worst();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_worst = $urandom_range(500);
         4, 5, 6:    pick_worst = -$signed($urandom_range(1, 500000));
         default:    pick_worst = pick_time();
      endcase
   endfunction

   task automatic random_load();
      logic [3:0] pair;
      pair = 4'($urandom);
      load_pair(pair[3:2], pair[1:0], pick_required(), pick_worst());
   endtask

   task automatic random_tag(input logic last);
      logic [3:0]         pair;
      logic signed [31:0] slack;
      pair = 4'($urandom);
      if (pair_loaded[pair] && pair_req_ps[pair] > 1 && $urandom_range(1))
         slack = $urandom_range(1, pair_req_ps[pair] - 1);
      else
         slack = pick_time();
      score_tag(pair[3:2], pair[1:0], slack, last);
   endtask

   task automatic test_score_extremes();
      load_pair(2'd0, 2'd0, 1000, 0);
      load_pair(2'd0, 2'd1, 1000, -500);
      load_pair(2'd0, 2'd2, 0, 0);
      load_pair(2'd0, 2'd3, -5, 0);
      load_pair(2'd1, 2'd0, 32'sh7fff_ffff, 32'sh8000_0000);
      load_pair(2'd1, 2'd1, 32'sh8000_0000, 32'sh7fff_ffff);
      score_tag(2'd0, 2'd0, 32'sh8000_0000, 1'b1);
      score_tag(2'd0, 2'd0, 0, 1'b1);
      score_tag(2'd0, 2'd0, 250, 1'b1);
      score_tag(2'd0, 2'd0, 1000, 1'b1);
      score_tag(2'd0, 2'd0, 32'sh7fff_ffff, 1'b1);
      score_tag(2'd0, 2'd1, 250, 1'b1);
      score_tag(2'd0, 2'd2, 0, 1'b1);
      score_tag(2'd0, 2'd2, 5, 1'b1);
      score_tag(2'd0, 2'd3, 0, 1'b1);
      score_tag(2'd1, 2'd0, 32'sh7fff_ffff, 1'b1);
      score_tag(2'd1, 2'd0, 1, 1'b1);
      score_tag(2'd1, 2'd1, 0, 1'b1);
   endtask

   task automatic test_node_max_and_sticky();
      score_tag(2'd2, 2'd2, 100, 1'b1);
      score_tag(2'd0, 2'd0, 900, 1'b0);
      score_tag(2'd0, 2'd0, 250, 1'b0);
      score_tag(2'd0, 2'd0, 600, 1'b1);
      score_tag(2'd0, 2'd0, 500, 1'b0);
      score_tag(2'd0, 2'd3, 0, 1'b0);
      score_tag(2'd3, 2'd1, 0, 1'b0);
      score_tag(2'd0, 2'd0, 100, 1'b1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int sent;
      int n_tags;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 15) begin
            random_load();
            sent++;
         end else begin
            n_tags = $urandom_range(1, 5);
            for (int k = 0; k < n_tags; k++) begin
               if ($urandom_range(99) < 8) begin
                  random_load();
                  sent++;
               end
               random_tag(k == n_tags - 1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      foreach (pair_loaded[i])
         pair_loaded[i] = 1'b0;
      node_max_crit = '0;
      node_error    = rtc_pkg::ERR_NONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_score_extremes();
      test_node_max_and_sticky();
      test_random_traffic(0, 0);
      test_random_traffic(74, 0);
      test_random_traffic(0, 74);
      test_random_traffic(29, 29);

      req_valid <= 1'b0;
      while (expected_node_scores.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scored %0d slack tags and %0d table loads under four idle and stall mixes;",
               tags_scored, loads_sent);
      $display("checked %0d node results, %0d failures.", nodes_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("** relaxed_timing_criticality: PASSED **");
      else
         $display("** relaxed_timing_criticality: FAILED **");
      $finish;
   end

endmodule
